FILE: rtl/lpe_pkg.sv
package lpe_pkg;

    localparam int unsigned BAND_W   = 8;
    localparam int unsigned LEVEL_W  = 17;
    localparam int unsigned HUE_W    = 16;
    localparam int unsigned COLOR_W  = 8;
    localparam int unsigned SEQ_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 17;

    // Brightness and fade rate are Q1.16, so 1.0 is 65536.
    localparam logic [LEVEL_W-1:0] ONE_Q16   = 17'd65536;
    // 0.003 in Q1.16, rounded: start level and decay floor.
    localparam logic [LEVEL_W-1:0] START_Q16 = 17'd197;
    // A full turn of hue in 1/128 degree units.
    localparam logic [LEVEL_W-1:0] FULL_TURN = 17'd46080;
    localparam logic [4:0]         LIN_DIV   = 5'd12;
    localparam logic [BAND_W-1:0]  TOP_BAND  = 8'h80;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EXP_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_RATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MASK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_MODE = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RISE  = 2'd1,
        PH_DECAY = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HUE,
        S_WRAP,
        S_STEP,
        S_APPLY,
        S_COLOR,
        S_OUT
    } t_state;

endpackage

FILE: rtl/led_pulse_envelope_core.sv
// o_out_valid rises after an input transfer once the item has passed the hue scan over the
// band bits, with wrap steps after each trigger, or a rise step in the bit-serial step unit,
// then the bit-serial color scaling and the output load, which waits while a result is stalled.
// One item at a time; after the result is loaded, a decaying pulse passes through the bit-serial
// step unit and the apply step before the next item is taken.
// Reset (synchronous, active low) clears the configuration, the envelope and the output valid.
module led_pulse_envelope_core #(
    parameter int NUM_BANDS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpe_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lpe_pkg::BAND_W-1:0]        i_band_rising,
    input  logic [lpe_pkg::SEQ_W-1:0]         i_analysis_seq,
    input  logic                              i_analysis_valid,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lpe_pkg::COLOR_W-1:0]       o_red,
    output logic [lpe_pkg::COLOR_W-1:0]       o_green,
    output logic [lpe_pkg::COLOR_W-1:0]       o_blue,
    output logic [lpe_pkg::LEVEL_W-1:0]       o_level,
    output logic [lpe_pkg::HUE_W-1:0]         o_hue
);

    // Bands beyond NUM_BANDS are never looked at.
    localparam logic [lpe_pkg::BAND_W-1:0] BAND_EN = ~(8'hFF >> NUM_BANDS);

    // Configuration registers.
    logic                             r_exp;
    logic [lpe_pkg::COLOR_W-1:0]      r_base_red;
    logic [lpe_pkg::COLOR_W-1:0]      r_base_green;
    logic [lpe_pkg::COLOR_W-1:0]      r_base_blue;
    logic [lpe_pkg::LEVEL_W-1:0]      r_fade;
    logic [lpe_pkg::BAND_W-1:0]       r_band_mask;
    logic [16:0]                      r_hue_step;
    logic                             r_audio;

    lpe_pkg::t_state                  r_state, n_state;
    lpe_pkg::t_phase                  r_phase, n_phase;
    logic [lpe_pkg::LEVEL_W-1:0]      r_bright, n_bright;
    logic [lpe_pkg::HUE_W-1:0]        r_hue, n_hue;
    logic [lpe_pkg::SEQ_W-1:0]        r_last_seq, n_last_seq;
    logic [lpe_pkg::BAND_W-1:0]       r_hits, n_hits;
    logic [17:0]                      r_hacc, n_hacc;
    logic [4:0]                       r_cnt, n_cnt;
    logic                             r_decay, n_decay;

    // Bit-serial step unit: multiply for proportional mode, divide by 12 for linear mode.
    logic [16:0]                      r_fsh, n_fsh;
    logic [32:0]                      r_sacc, n_sacc;
    logic [3:0]                       r_rem, n_rem;
    logic [16:0]                      r_quot, n_quot;

    // Three bit-serial color lanes sharing the brightness as multiplicand.
    logic [7:0]                       r_csh_r, n_csh_r;
    logic [7:0]                       r_csh_g, n_csh_g;
    logic [7:0]                       r_csh_b, n_csh_b;
    logic [23:0]                      r_cacc_r, n_cacc_r;
    logic [23:0]                      r_cacc_g, n_cacc_g;
    logic [23:0]                      r_cacc_b, n_cacc_b;

    logic                             r_out_valid, n_out_valid;
    logic [lpe_pkg::COLOR_W-1:0]      r_out_red, n_out_red;
    logic [lpe_pkg::COLOR_W-1:0]      r_out_green, n_out_green;
    logic [lpe_pkg::COLOR_W-1:0]      r_out_blue, n_out_blue;
    logic [lpe_pkg::LEVEL_W-1:0]      r_out_level, n_out_level;
    logic [lpe_pkg::HUE_W-1:0]        r_out_hue, n_out_hue;

    logic                             in_xfer;
    logic [lpe_pkg::LEVEL_W-1:0]      fade_clamped;
    logic [lpe_pkg::BAND_W-1:0]       audio_hits;
    logic                             fbit;
    logic [4:0]                       rem5;
    logic [16:0]                      step;
    logic [17:0]                      rise_sum;
    logic [17:0]                      decay_diff;
    logic [17:0]                      hue_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != lpe_pkg::S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;

    assign fade_clamped = (r_fade > lpe_pkg::ONE_Q16) ? lpe_pkg::ONE_Q16 : r_fade;
    assign audio_hits   = r_band_mask & i_band_rising & BAND_EN;

    assign fbit       = r_fsh[16];
    assign rem5       = {r_rem, fbit};
    assign step       = r_exp ? r_sacc[32:16] : r_quot;
    assign rise_sum   = {1'b0, r_bright} + {1'b0, step};
    assign decay_diff = {1'b0, r_bright} - {1'b0, step};
    assign hue_sum    = {2'b00, r_hue} + {r_hue_step[16], r_hue_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp        <= 1'b0;
            r_base_red   <= '0;
            r_base_green <= '0;
            r_base_blue  <= '0;
            r_fade       <= '0;
            r_band_mask  <= '0;
            r_hue_step   <= '0;
            r_audio      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lpe_pkg::REG_EXP_MODE:   r_exp        <= i_cfg_data[0];
                lpe_pkg::REG_BASE_RED:   r_base_red   <= i_cfg_data[7:0];
                lpe_pkg::REG_BASE_GREEN: r_base_green <= i_cfg_data[7:0];
                lpe_pkg::REG_BASE_BLUE:  r_base_blue  <= i_cfg_data[7:0];
                lpe_pkg::REG_FADE_RATE:  r_fade       <= i_cfg_data;
                lpe_pkg::REG_BAND_MASK:  r_band_mask  <= i_cfg_data[7:0];
                lpe_pkg::REG_HUE_STEP:   r_hue_step   <= i_cfg_data;
                lpe_pkg::REG_AUDIO_MODE: r_audio      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpe_pkg::S_IDLE;
            r_phase     <= lpe_pkg::PH_IDLE;
            r_bright    <= '0;
            r_hue       <= '0;
            r_last_seq  <= '0;
            r_hits      <= '0;
            r_cnt       <= '0;
            r_decay     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bright    <= n_bright;
            r_hue       <= n_hue;
            r_last_seq  <= n_last_seq;
            r_hits      <= n_hits;
            r_cnt       <= n_cnt;
            r_decay     <= n_decay;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hacc      <= n_hacc;
        r_fsh       <= n_fsh;
        r_sacc      <= n_sacc;
        r_rem       <= n_rem;
        r_quot      <= n_quot;
        r_csh_r     <= n_csh_r;
        r_csh_g     <= n_csh_g;
        r_csh_b     <= n_csh_b;
        r_cacc_r    <= n_cacc_r;
        r_cacc_g    <= n_cacc_g;
        r_cacc_b    <= n_cacc_b;
        r_out_red   <= n_out_red;
        r_out_green <= n_out_green;
        r_out_blue  <= n_out_blue;
        r_out_level <= n_out_level;
        r_out_hue   <= n_out_hue;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_bright    = r_bright;
        n_hue       = r_hue;
        n_last_seq  = r_last_seq;
        n_hits      = r_hits;
        n_hacc      = r_hacc;
        n_cnt       = r_cnt;
        n_decay     = r_decay;
        n_fsh       = r_fsh;
        n_sacc      = r_sacc;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_csh_r     = r_csh_r;
        n_csh_g     = r_csh_g;
        n_csh_b     = r_csh_b;
        n_cacc_r    = r_cacc_r;
        n_cacc_g    = r_cacc_g;
        n_cacc_b    = r_cacc_b;
        n_out_valid = r_out_valid;
        n_out_red   = r_out_red;
        n_out_green = r_out_green;
        n_out_blue  = r_out_blue;
        n_out_level = r_out_level;
        n_out_hue   = r_out_hue;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lpe_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_hits  = '0;
                    n_state = lpe_pkg::S_HUE;
                    if (r_audio) begin
                        // A stale or invalid analysis triggers nothing.
                        if (i_analysis_valid && (i_analysis_seq != r_last_seq)) begin
                            n_last_seq = i_analysis_seq;
                            n_hits     = audio_hits;
                            if (audio_hits != '0) begin
                                n_phase  = lpe_pkg::PH_DECAY;
                                n_bright = lpe_pkg::ONE_Q16;
                            end
                        end
                    end else begin
                        unique case (r_phase)
                            lpe_pkg::PH_IDLE: begin
                                n_phase  = lpe_pkg::PH_RISE;
                                n_bright = lpe_pkg::START_Q16;
                                n_hits   = lpe_pkg::TOP_BAND;
                            end
                            lpe_pkg::PH_RISE: begin
                                n_fsh   = fade_clamped;
                                n_sacc  = '0;
                                n_rem   = '0;
                                n_quot  = '0;
                                n_cnt   = 5'd16;
                                n_decay = 1'b0;
                                n_state = lpe_pkg::S_STEP;
                            end
                            default: ;
                        endcase
                    end
                end
            end

            lpe_pkg::S_HUE: begin
                // Scan the trigger bits from band 0; each hit adds one hue step.
                if (r_hits == '0) begin
                    n_csh_r  = r_base_red;
                    n_csh_g  = r_base_green;
                    n_csh_b  = r_base_blue;
                    n_cacc_r = '0;
                    n_cacc_g = '0;
                    n_cacc_b = '0;
                    n_cnt    = 5'd7;
                    n_state  = lpe_pkg::S_COLOR;
                end else begin
                    n_hits = {r_hits[6:0], 1'b0};
                    if (r_hits[7]) begin
                        n_hacc  = hue_sum;
                        n_state = lpe_pkg::S_WRAP;
                    end
                end
            end

            lpe_pkg::S_WRAP: begin
                if (r_hacc[17]) begin
                    n_hacc = r_hacc + {1'b0, lpe_pkg::FULL_TURN};
                end else if (r_hacc[16:0] >= lpe_pkg::FULL_TURN) begin
                    n_hacc = r_hacc - {1'b0, lpe_pkg::FULL_TURN};
                end else begin
                    n_hue   = r_hacc[15:0];
                    n_state = lpe_pkg::S_HUE;
                end
            end

            lpe_pkg::S_STEP: begin
                n_fsh  = {r_fsh[15:0], 1'b0};
                n_sacc = {r_sacc[31:0], 1'b0} + (fbit ? {16'b0, r_bright} : 33'b0);
                if (rem5 >= lpe_pkg::LIN_DIV) begin
                    n_rem  = 4'(rem5 - lpe_pkg::LIN_DIV);
                    n_quot = {r_quot[15:0], 1'b1};
                end else begin
                    n_rem  = rem5[3:0];
                    n_quot = {r_quot[15:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = lpe_pkg::S_APPLY;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end

            lpe_pkg::S_APPLY: begin
                if (r_decay) begin
                    // Falling below the floor, or past zero, ends the pulse.
                    if (decay_diff[17] || (decay_diff[16:0] < lpe_pkg::START_Q16)) begin
                        n_bright = '0;
                        n_phase  = lpe_pkg::PH_IDLE;
                    end else begin
                        n_bright = decay_diff[16:0];
                    end
                    n_state = lpe_pkg::S_IDLE;
                end else begin
                    if (rise_sum >= {1'b0, lpe_pkg::ONE_Q16}) begin
                        n_bright = lpe_pkg::ONE_Q16;
                        n_phase  = lpe_pkg::PH_DECAY;
                    end else begin
                        n_bright = rise_sum[16:0];
                    end
                    n_csh_r  = r_base_red;
                    n_csh_g  = r_base_green;
                    n_csh_b  = r_base_blue;
                    n_cacc_r = '0;
                    n_cacc_g = '0;
                    n_cacc_b = '0;
                    n_cnt    = 5'd7;
                    n_state  = lpe_pkg::S_COLOR;
                end
            end

            lpe_pkg::S_COLOR: begin
                n_csh_r  = {r_csh_r[6:0], 1'b0};
                n_csh_g  = {r_csh_g[6:0], 1'b0};
                n_csh_b  = {r_csh_b[6:0], 1'b0};
                n_cacc_r = {r_cacc_r[22:0], 1'b0} + (r_csh_r[7] ? {7'b0, r_bright} : 24'b0);
                n_cacc_g = {r_cacc_g[22:0], 1'b0} + (r_csh_g[7] ? {7'b0, r_bright} : 24'b0);
                n_cacc_b = {r_cacc_b[22:0], 1'b0} + (r_csh_b[7] ? {7'b0, r_bright} : 24'b0);
                if (r_cnt == '0) begin
                    n_state = lpe_pkg::S_OUT;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end

            lpe_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_red   = r_cacc_r[23:16];
                    n_out_green = r_cacc_g[23:16];
                    n_out_blue  = r_cacc_b[23:16];
                    n_out_level = r_bright;
                    n_out_hue   = r_hue;
                    if (r_phase == lpe_pkg::PH_DECAY) begin
                        n_fsh   = fade_clamped;
                        n_sacc  = '0;
                        n_rem   = '0;
                        n_quot  = '0;
                        n_cnt   = 5'd16;
                        n_decay = 1'b1;
                        n_state = lpe_pkg::S_STEP;
                    end else begin
                        n_state = lpe_pkg::S_IDLE;
                    end
                end
            end

            default: n_state = lpe_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_red;
    assign o_green     = r_out_green;
    assign o_blue      = r_out_blue;
    assign o_level     = r_out_level;
    assign o_hue       = r_out_hue;

endmodule

FILE: rtl/lpe_checker.sv
module lpe_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [lpe_pkg::COLOR_W-1:0]       o_red,
    input logic [lpe_pkg::COLOR_W-1:0]       o_green,
    input logic [lpe_pkg::COLOR_W-1:0]       o_blue,
    input logic [lpe_pkg::LEVEL_W-1:0]       o_level,
    input logic [lpe_pkg::HUE_W-1:0]         o_hue
);

    // A result that is held back stays put until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_red) && $stable(o_green) && $stable(o_blue)
            && $stable(o_level) && $stable(o_hue))
        else $error("result changed while stalled");

    // Items are worked on one at a time, so an input transfer closes the input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_level <= lpe_pkg::ONE_Q16)
        else $error("level above full scale");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {1'b0, o_hue} < lpe_pkg::FULL_TURN)
        else $error("hue not wrapped");

    // A dark frame has no color.
    a_dark_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_level == '0) |-> (o_red == '0) && (o_green == '0) && (o_blue == '0))
        else $error("color at zero level");

endmodule

bind led_pulse_envelope_core lpe_checker u_lpe_checker (.*);
